// ----- hw/rtl/lru_key_value_cache_macros.svh -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_macros
// assertion macros for the lru key-value cache
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH
`ifndef SYNTHESIS
`define LKV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define LKV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants of the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none
package lkv_pkg;
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
	typedef struct packed {
		logic        func;
		logic [31:0] key;
		logic [31:0] value;
	} cmd_t;
endpackage
`default_nettype wire

// ----- hw/rtl/lkv_front.sv -----
// ----------------------------------------------------------------------------
// lkv_front
// accepts commands and places them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module lkv_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          flush,
	input  wire logic          push,
	input  wire lkv_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output lkv_pkg::cmd_t      head
);
	lkv_pkg::cmd_t buf_q [2];
	logic          rd_q;
	logic          wr_q;
	logic [1:0]    cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else if (flush) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= push_cmd;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/lkv_back.sv -----
// ----------------------------------------------------------------------------
// lkv_back
// recency-ordered slot chain: the search, then the shift in the cycle that comes next
// ----------------------------------------------------------------------------
`default_nettype none
module lkv_back #(
	parameter int ENTRIES = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clear,
	input  wire logic [4:0]    capacity,
	input  wire logic          cmd_valid,
	input  wire lkv_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               idle,
	output logic               done,
	output logic               hit,
	output logic [31:0]        read_value
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic {ST_SEARCH, ST_SHIFT} state_t;

	state_t        state_q;
	logic [31:0]   key_q   [ENTRIES];
	logic [31:0]   val_q   [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	lkv_pkg::cmd_t cmd_s1;
	logic          hit_s1;
	logic [IW-1:0] pos_s1;
	logic          done_q;
	logic          hit_q;
	logic [31:0]   rv_q;

	logic [ENTRIES-1:0] match;
	logic          any_hit;
	logic [IW-1:0] hit_pos;
	logic [IW:0]   lim;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) match[i] = vld_q[i] && (key_q[i] == cmd.key);
		any_hit = |match;
		hit_pos = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) if (match[i]) hit_pos = IW'(i);
		if ({{(32-5){1'b0}}, capacity} < ENTRIES) lim = (IW+1)'(capacity);
		else lim = (IW+1)'(ENTRIES);
	end

	assign cmd_pop    = (state_q == ST_SEARCH) && cmd_valid && !clear;
	assign idle       = (state_q == ST_SEARCH);
	assign done       = done_q;
	assign hit        = hit_q;
	assign read_value = rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEARCH;
			vld_q   <= '0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
			rv_q    <= '0;
		end else if (clear) begin
			state_q <= ST_SEARCH;
			vld_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_SEARCH: begin
					if (cmd_valid) state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					state_q <= ST_SEARCH;
					if (cmd_s1.func == lkv_pkg::FUNC_GET) begin
						done_q <= 1'b1;
						hit_q  <= hit_s1;
						rv_q   <= hit_s1 ? val_q[pos_s1] : lkv_pkg::MISS_VALUE;
					end
					if (hit_s1 || cmd_s1.func == lkv_pkg::FUNC_PUT) begin
						// slot i takes slot i-1 for i up to the hit slot (or all)
						for (int i = 1; i < ENTRIES; i++)
							if (!hit_s1 || IW'(i) <= pos_s1) vld_q[i] <= vld_q[i-1];
						vld_q[0] <= 1'b1;
						// trim entries at and beyond the limit
						for (int i = 0; i < ENTRIES; i++)
							if ((IW+1)'(i) >= lim) vld_q[i] <= 1'b0;
					end
				end
				default: state_q <= ST_SEARCH;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd;
			hit_s1 <= any_hit;
			pos_s1 <= hit_pos;
		end
		if (state_q == ST_SHIFT && !clear &&
		    (hit_s1 || cmd_s1.func == lkv_pkg::FUNC_PUT)) begin
			for (int i = 1; i < ENTRIES; i++)
				if (!hit_s1 || IW'(i) <= pos_s1) begin
					key_q[i] <= key_q[i-1];
					val_q[i] <= val_q[i-1];
				end
			key_q[0] <= cmd_s1.key;
			val_q[0] <= (cmd_s1.func == lkv_pkg::FUNC_PUT) ? cmd_s1.value : val_q[pos_s1];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// channel | signals                        | transfer when
// command | start, busy, func, key, value  | start && !busy
// result  | result_valid, hit, read_value  | result_valid (one cycle)
// config  | capacity_we, capacity_wdata    | capacity_we
//
// in the back end each command passes a parallel key search over
// the slot chain, then on a hit or a put a one-step shift of the chain that moves
// the entry to the front; a get result appears the cycle after the shift
// a two-entry queue sits between command intake and the back end
// reset and any capacity write empty the store and the queue at once
// the receiver cannot stall; busy rises only when the queue is full
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_key_value_cache_macros.svh"
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [31:0] key,
	input  wire logic [31:0] value,
	output logic             result_valid,
	output logic             hit,
	output logic [31:0]      read_value,
	input  wire logic        capacity_we,
	input  wire logic [4:0]  capacity_wdata
);
	logic [4:0]    capacity_q;
	logic          full;
	logic          not_empty;
	logic          pop;
	logic          back_idle;
	logic          accept;
	lkv_pkg::cmd_t head;
	lkv_pkg::cmd_t in_cmd;

	// capacity register, reset to sixteen entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= 5'd16;
		else if (capacity_we) capacity_q <= capacity_wdata;
	end

	assign busy   = full;
	assign accept = start && !busy;
	assign in_cmd = '{func: func, key: key, value: value};

	// front: command queue
	lkv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.flush     (capacity_we),
		.push      (accept),
		.push_cmd  (in_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// back: search and reorder the slot chain
	lkv_back #(.ENTRIES(ENTRIES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (capacity_we),
		.capacity   (capacity_q),
		.cmd_valid  (not_empty),
		.cmd        (head),
		.cmd_pop    (pop),
		.idle       (back_idle),
		.done       (result_valid),
		.hit        (hit),
		.read_value (read_value)
	);

	// a miss always returns all ones
	`LKV_ASSERT_IMPL(a_miss_value, clk, arst_n, result_valid && !hit, read_value == lkv_pkg::MISS_VALUE)
	// a pop only happens while the back end waits for work
	`LKV_ASSERT_IMPL(a_pop_idle, clk, arst_n, pop, back_idle && not_empty)
	// after a pop the back end is in its shift step
	`LKV_ASSERT_NEXT(a_pop_shift, clk, arst_n, pop && !capacity_we, !back_idle)
endmodule
`default_nettype wire
